// File: src/bbfd_pkg.sv
// Package with the request types, register indexes and constants of the fall detector.
`default_nettype none

package bbfd_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned ARITH_W = 24;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned DIVISOR_W = 4;

    // Motion thresholds: a fraction 1/N of the box height, and the edge margin.
    localparam logic signed [ARITH_W-1:0] BOTTOM_DROP_DIV = 24'sd50;
    localparam logic signed [ARITH_W-1:0] TOP_FALL_DIV = 24'sd40;
    localparam logic signed [ARITH_W-1:0] TOP_RISE_DIV = 24'sd80;
    localparam logic signed [ARITH_W-1:0] EDGE_MARGIN = 24'sd5;
    localparam logic signed [ARITH_W-1:0] NARROW_DIV = 24'sd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [COORD_W-1:0] FRAME_WIDTH_RESET = 12'd640;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 4'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH = 1'b0,
        REG_HEIGHT_DROP_DIVISOR = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
    } box_t;

    typedef struct packed {
        logic warning;
        logic alarm;
    } result_t;

    // Controls broadcast from the sequencer to every window cell.
    typedef struct packed {
        logic load;
        logic shift;
        logic scan;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/bbfd_cell.sv
// One window cell: holds one stored box top and height and one stage of the max scan.
`default_nettype none

module bbfd_cell (
    input  wire logic                           clk,
    input  wire bbfd_pkg::cell_ctrl_t           ctrl,
    input  wire logic [bbfd_pkg::COORD_W-1:0]   fill_top,
    input  wire logic [bbfd_pkg::COORD_W-1:0]   fill_height,
    input  wire logic [bbfd_pkg::COORD_W-1:0]   top_in,
    input  wire logic [bbfd_pkg::COORD_W-1:0]   height_in,
    input  wire logic [bbfd_pkg::COORD_W-1:0]   max_in,
    output logic      [bbfd_pkg::COORD_W-1:0]   top,
    output logic      [bbfd_pkg::COORD_W-1:0]   height,
    output logic      [bbfd_pkg::COORD_W-1:0]   max_out
);

    logic [bbfd_pkg::COORD_W-1:0] top_reg;
    logic [bbfd_pkg::COORD_W-1:0] height_reg;
    logic [bbfd_pkg::COORD_W-1:0] max_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            top_reg    <= fill_top;
            height_reg <= fill_height;
        end
        else if (ctrl.shift)
        begin
            top_reg    <= top_in;
            height_reg <= height_in;
        end
        if (ctrl.scan)
        begin
            max_reg <= (height_reg > max_in) ? height_reg : max_in;
        end
    end

    assign top     = top_reg;
    assign height  = height_reg;
    assign max_out = max_reg;

endmodule

`default_nettype wire

// File: src/bounding_box_fall_detector_top.sv
// Top level of the bounding box fall detector: sequencer, window cell chain and decision logic.
`default_nettype none

// Fall detector for one tracked person. Each request carries one bounding box per
// video frame; each request yields exactly one result with the warning and alarm
// flags after that frame. The window of the last HISTORY boxes lives in a chain of
// HISTORY identical cells, the newest at the far end. The first box after reset fills
// every cell. The window maximum height is found by a running maximum that passes
// from cell to cell, one cell per clock, so a request passes through the scan state,
// which runs the maximum through the chain, and then the decision state, which also
// shifts the box into the window. The next request is taken in the cycle after the
// decision, so a new request is never taken before the last one is through. The result
// sits in an output register, so a new request is taken while the previous result
// still waits; the decision state waits only if that register is still full.
// Configuration writes are always taken and should be issued while the block is idle.
module bounding_box_fall_detector_top #(
    parameter int unsigned HISTORY = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire bbfd_pkg::box_t                     in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output bbfd_pkg::result_t                       out_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bbfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bbfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned SCAN_W = $clog2(HISTORY);
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(HISTORY - 1);
    localparam int unsigned AW = bbfd_pkg::ARITH_W;
    localparam int unsigned CW = bbfd_pkg::COORD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    logic [SCAN_W-1:0] scan_cnt_reg;
    logic primed_reg;
    logic warning_reg;
    logic alarm_reg;
    logic [bbfd_pkg::COUNT_W-1:0] fall_count_reg;
    logic out_valid_reg;
    bbfd_pkg::result_t out_data_reg;
    bbfd_pkg::box_t box_reg;
    logic [CW-1:0] frame_width_reg;
    logic [bbfd_pkg::DIVISOR_W-1:0] divisor_reg;

    logic in_fire;
    logic decide_go;
    bbfd_pkg::cell_ctrl_t ctrl;

    // Cell chain wiring.
    logic [CW-1:0] cell_top [HISTORY];
    logic [CW-1:0] cell_height [HISTORY];
    logic [CW-1:0] cell_max [HISTORY];

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign decide_go = (state_reg == ST_DECIDE) && (!out_valid_reg || out_ready);

    // The first box after reset is written into every cell as it is accepted.
    assign ctrl.load  = in_fire && !primed_reg;
    assign ctrl.shift = decide_go;
    assign ctrl.scan  = (state_reg == ST_SCAN);

    for (genvar i = 0; i < HISTORY; i++)
    begin : g_cell
        logic [CW-1:0] top_from_upper;
        logic [CW-1:0] height_from_upper;
        logic [CW-1:0] max_from_lower;

        if (i == HISTORY - 1)
        begin : g_newest
            assign top_from_upper    = box_reg.box_top;
            assign height_from_upper = box_reg.box_height;
        end
        else
        begin : g_inner
            assign top_from_upper    = cell_top[i+1];
            assign height_from_upper = cell_height[i+1];
        end

        if (i == 0)
        begin : g_first
            assign max_from_lower = '0;
        end
        else
        begin : g_rest
            assign max_from_lower = cell_max[i-1];
        end

        bbfd_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .fill_top    (in_data.box_top),
            .fill_height (in_data.box_height),
            .top_in      (top_from_upper),
            .height_in   (height_from_upper),
            .max_in      (max_from_lower),
            .top         (cell_top[i]),
            .height      (cell_height[i]),
            .max_out     (cell_max[i])
        );
    end

    // Decision logic, evaluated in the decision cycle. Every "x > h/N" test on a
    // truncated quotient is rewritten as the equivalent "N*x > h", and "w < h/3"
    // as "3*(w+1) <= h", so no division is needed.
    logic signed [AW-1:0] l_s, t_s, w_s, h_s, p1t_s, p1h_s, p2t_s, fw_s;
    logic signed [AW-1:0] bottom_gap;
    logic set_warn, clear_warn, warning_next;
    logic at_edge, narrow, at_side;
    logic [bbfd_pkg::COUNT_W-1:0] fall_count_next;
    logic [CW:0] h_plus_one;
    logic [CW+bbfd_pkg::DIVISOR_W:0] scaled_height;
    logic alarm_next;
    logic [CW-1:0] max_height;

    assign max_height = cell_max[HISTORY-1];

    always_comb
    begin
        l_s   = AW'(signed'({1'b0, box_reg.box_left}));
        t_s   = AW'(signed'({1'b0, box_reg.box_top}));
        w_s   = AW'(signed'({1'b0, box_reg.box_width}));
        h_s   = AW'(signed'({1'b0, box_reg.box_height}));
        p1t_s = AW'(signed'({1'b0, cell_top[HISTORY-1]}));
        p1h_s = AW'(signed'({1'b0, cell_height[HISTORY-1]}));
        p2t_s = AW'(signed'({1'b0, cell_top[HISTORY-2]}));
        fw_s  = AW'(signed'({1'b0, frame_width_reg}));

        bottom_gap = (t_s + h_s) - (p1t_s + p1h_s);
        set_warn   = (bbfd_pkg::BOTTOM_DROP_DIV * (24'sd1 - bottom_gap) <= h_s)
                  && (bbfd_pkg::TOP_FALL_DIV * (t_s - p1t_s) > h_s)
                  && (bbfd_pkg::TOP_FALL_DIV * (p1t_s - p2t_s) > h_s);
        clear_warn = (bbfd_pkg::TOP_RISE_DIV * (p1t_s - t_s) > h_s)
                  && (bbfd_pkg::TOP_RISE_DIV * (p2t_s - p1t_s) > h_s);

        warning_next = warning_reg;
        if (set_warn)
        begin
            warning_next = 1'b1;
        end
        if (clear_warn)
        begin
            warning_next = 1'b0;
        end

        at_side = (l_s < bbfd_pkg::EDGE_MARGIN)
               || ((fw_s - (l_s + w_s)) < bbfd_pkg::EDGE_MARGIN);
        narrow  = (bbfd_pkg::NARROW_DIV * (w_s + 24'sd1)) <= h_s;
        at_edge = at_side && narrow;

        fall_count_next = fall_count_reg;
        alarm_next      = alarm_reg;
        if (warning_next)
        begin
            if (!at_edge && (fall_count_reg != bbfd_pkg::COUNT_MAX))
            begin
                fall_count_next = fall_count_reg + 1'b1;
            end
        end
        else
        begin
            fall_count_next = '0;
            alarm_next      = 1'b0;
        end

        h_plus_one    = {1'b0, box_reg.box_height} + 1'b1;
        scaled_height = h_plus_one * divisor_reg;
        if ((fall_count_next > bbfd_pkg::COUNT_W'(HISTORY))
            && (scaled_height <= (CW+bbfd_pkg::DIVISOR_W+1)'(max_height)))
        begin
            alarm_next = 1'b1;
        end
    end

    // Request register and configuration registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            box_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= bbfd_pkg::FRAME_WIDTH_RESET;
            divisor_reg     <= bbfd_pkg::DIVISOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bbfd_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data;
                end
                bbfd_pkg::REG_HEIGHT_DROP_DIVISOR:
                begin
                    divisor_reg <= cfg_data[bbfd_pkg::DIVISOR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer, detector state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            primed_reg     <= 1'b0;
            warning_reg    <= 1'b0;
            alarm_reg      <= 1'b0;
            fall_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        primed_reg   <= 1'b1;
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == SCAN_LAST)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (decide_go)
                    begin
                        warning_reg          <= warning_next;
                        alarm_reg            <= alarm_next;
                        fall_count_reg       <= fall_count_next;
                        out_valid_reg        <= 1'b1;
                        out_data_reg.warning <= warning_next;
                        out_data_reg.alarm   <= alarm_next;
                        state_reg            <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
